FILE: design/assert_macros.svh
// Assertion macros used by the window filter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GWF_ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GWF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/gwf_pkg.sv
// Types and constants of the geodesic window filter.
package gwf_pkg;

  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned VALUE_WIDTH = 48;
  localparam int unsigned DIST_W      = VALUE_WIDTH - 1;
  localparam int unsigned PROP_W      = 25;
  localparam int unsigned LEN_SPLIT   = 24;
  localparam int unsigned POS_W       = 48;
  localparam int unsigned MAG_W       = 49;
  localparam int unsigned SQ_W        = 2 * MAG_W;
  localparam int unsigned SUM_W       = SQ_W + 1;
  localparam int unsigned ROOT_W      = (SUM_W + 1) / 2;
  localparam int unsigned DMAG_W      = 51;
  localparam int unsigned DSQ_W       = 2 * DMAG_W;

  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(64'd10000 << FRAC_BITS);

  localparam logic [1:0] KIND_PSEUDO = 2'd0;
  localparam logic [1:0] KIND_LEFT   = 2'd1;

  localparam logic [1:0] REASON_NONE     = 2'd0;
  localparam logic [1:0] REASON_LEFT     = 2'd1;
  localparam logic [1:0] REASON_RIGHT    = 2'd2;
  localparam logic [1:0] REASON_OPPOSITE = 2'd3;

  typedef struct packed {
    logic [1:0]              parent_kind;
    logic [DIST_W-1:0]       edge_length;
    logic [PROP_W-1:0]       prop_start;
    logic [PROP_W-1:0]       prop_end;
    logic signed [VALUE_WIDTH-1:0] source_x;
    logic signed [VALUE_WIDTH-1:0] source_y;
    logic [DIST_W-1:0]       root_distance;
    logic [DIST_W-1:0]       left_vertex_dist;
    logic [DIST_W-1:0]       right_vertex_dist;
    logic [DIST_W-1:0]       opposite_vertex_dist;
    logic signed [VALUE_WIDTH-1:0] opposite_x;
    logic signed [VALUE_WIDTH-1:0] opposite_y;
  } gwf_in_t;

  typedef struct packed {
    logic       window_valid;
    logic [1:0] reject_reason;
  } gwf_out_t;

  // Per-window values carried alongside the squares and roots.
  typedef struct packed {
    logic                     pass;
    logic                     from_start;
    logic [2:0]               known;      // {opposite, right, left}
    logic [DIST_W+1:0]        lhs_l;      // left dist + end position
    logic [DIST_W:0]          lhs_r;      // right dist + edge length
    logic [DIST_W-1:0]        root;
    logic [DIST_W+1:0]        root_ps;    // root + start position
    logic signed [DIST_W:0]   root_m_dop; // root - opposite dist
  } gwf_pre_t;

  typedef struct packed {
    gwf_pre_t         pre;
    logic [SUM_W-1:0] n_o;
  } gwf_side_t;

  typedef struct packed {
    logic             pass;
    logic             rej_l;
    logic             rej_r;
    logic             chk_o;
    logic [SUM_W-1:0] n_o;
  } gwf_tail_t;

endpackage

FILE: design/gwf_square.sv
// Two-stage pipelined square built from half-width partial products.
module gwf_square #(
  parameter int unsigned W = gwf_pkg::MAG_W
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   a_i,
  output logic [2*W-1:0] sq_o
);

  localparam int unsigned H  = (W + 1) / 2;
  localparam int unsigned HW = W - H;

  logic [2*HW-1:0] hh_q;
  logic [W-1:0]    hl_q;
  logic [2*H-1:0]  ll_q;
  logic [2*W-1:0]  sq_d, sq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= a_i[W-1:H] * a_i[W-1:H];
      hl_q <= a_i[W-1:H] * a_i[H-1:0];
      ll_q <= a_i[H-1:0] * a_i[H-1:0];
      sq_q <= sq_d;
    end
  end

  always_comb begin
    sq_d = ((2*W)'(hh_q) << (2*H)) + ((2*W)'(hl_q) << (H+1)) + (2*W)'(ll_q);
  end

  assign sq_o = sq_q;

endmodule

FILE: design/gwf_isqrt.sv
// Two-lane floor square root, one result bit per pipeline stage.
module gwf_isqrt (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [1:0][gwf_pkg::SUM_W-1:0]         rad_i,
  input  gwf_pkg::gwf_side_t                     side_i,
  output logic                                   valid_o,
  output logic [1:0][gwf_pkg::ROOT_W-1:0]        root_o,
  output gwf_pkg::gwf_side_t                     side_o
);

  localparam int unsigned RW   = gwf_pkg::ROOT_W;
  localparam int unsigned RADW = 2 * RW;

  logic               vld_q  [RW];
  gwf_pkg::gwf_side_t side_q [RW];
  logic [RW+1:0]      rem_q  [2][RW];
  logic [RW-1:0]      root_q [2][RW];
  logic [RADW-1:0]    rad_q  [2][RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= (k == 0) ? side_i : side_q[(k == 0) ? 0 : k-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW+1:0]   rem_p;
      logic [RW-1:0]   root_p;
      logic [RADW-1:0] rad_p;
      logic [RW+3:0]   r2, tr, diff;
      logic            ge;

      if (k == 0) begin : g_first
        assign rem_p  = '0;
        assign root_p = '0;
        assign rad_p  = RADW'(rad_i[l]);
      end else begin : g_next
        assign rem_p  = rem_q[l][k-1];
        assign root_p = root_q[l][k-1];
        assign rad_p  = rad_q[l][k-1];
      end

      // Bring down two radicand bits, try root*4+1.
      assign r2   = {rem_p, rad_p[RADW-1 -: 2]};
      assign tr   = {2'b00, root_p, 2'b01};
      assign ge   = (r2 >= tr);
      assign diff = r2 - tr;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][k]  <= ge ? diff[RW+1:0] : r2[RW+1:0];
          root_q[l][k] <= {root_p[RW-2:0], ge};
          rad_q[l][k]  <= rad_p << 2;
        end
      end
    end
  end

  assign valid_o   = vld_q[RW-1];
  assign side_o    = side_q[RW-1];
  assign root_o[0] = root_q[0][RW-1];
  assign root_o[1] = root_q[1][RW-1];

endmodule

FILE: design/geodesic_window_filter_core.sv
// Geodesic window filter core: a fixed pipeline that judges one candidate
// window per cycle. From accepted input to result a window passes through
// nine arithmetic stages, the 50 stages of the bit-per-stage square root
// unit, and the output register. A new window is accepted every cycle the
// output is free or being taken; when the output stalls, the whole
// pipeline holds. Write known_distance_limit only while no window is in
// flight.
`include "assert_macros.svh"

module geodesic_window_filter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  gwf_pkg::gwf_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output gwf_pkg::gwf_out_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [gwf_pkg::DIST_W-1:0]         cfg_wdata_i
);

  localparam int unsigned DW  = gwf_pkg::DIST_W;
  localparam int unsigned PW  = gwf_pkg::POS_W;
  localparam int unsigned MW  = gwf_pkg::MAG_W;
  localparam int unsigned SW  = gwf_pkg::SUM_W;
  localparam int unsigned RW  = gwf_pkg::ROOT_W;
  localparam int unsigned SPL = gwf_pkg::LEN_SPLIT;
  localparam int unsigned PRW = PW + gwf_pkg::PROP_W;
  localparam int unsigned HI_W = DW - SPL;

  logic en;
  logic [DW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= gwf_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: edge position partial products, known flags.
  logic v1_q;
  gwf_pkg::gwf_in_t in1_q;
  logic [gwf_pkg::PROP_W+SPL-1:0]  pslo_q, pelo_q;
  logic [gwf_pkg::PROP_W+HI_W-1:0] pshi_q, pehi_q;
  logic [2:0] known1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q    <= in_data_i;
      pslo_q   <= in_data_i.prop_start * in_data_i.edge_length[SPL-1:0];
      pshi_q   <= in_data_i.prop_start * in_data_i.edge_length[DW-1:SPL];
      pelo_q   <= in_data_i.prop_end * in_data_i.edge_length[SPL-1:0];
      pehi_q   <= in_data_i.prop_end * in_data_i.edge_length[DW-1:SPL];
      known1_q <= {in_data_i.opposite_vertex_dist < limit_q,
                   in_data_i.right_vertex_dist < limit_q,
                   in_data_i.left_vertex_dist < limit_q};
    end
  end

  // Stage 2: rounded edge positions.
  logic v2_q;
  gwf_pkg::gwf_in_t in2_q;
  logic [2:0] known2_q;
  logic [PW-1:0] pos_s_q, pos_e_q;
  logic [PRW:0] pfull_s, pfull_e;
  localparam logic [PRW:0] HALF = (PRW+1)'(1) << (gwf_pkg::FRAC_BITS - 1);

  assign pfull_s = ((PRW+1)'(pshi_q) << SPL) + (PRW+1)'(pslo_q) + HALF;
  assign pfull_e = ((PRW+1)'(pehi_q) << SPL) + (PRW+1)'(pelo_q) + HALF;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in2_q    <= in1_q;
      known2_q <= known1_q;
      pos_s_q  <= PW'(pfull_s >> gwf_pkg::FRAC_BITS);
      pos_e_q  <= PW'(pfull_e >> gwf_pkg::FRAC_BITS);
    end
  end

  // Stage 3: magnitudes of the coordinate differences, sums for the tests.
  logic v3_q;
  gwf_pkg::gwf_pre_t pre3_q;
  logic [MW-1:0] m_e_q, m_s_q, m_sy_q, m_v_q, m_oy_q;
  logic signed [MW:0] dx_e, dx_s, dvx, sy_w, oy_w;
  logic [PW-1:0] pos_sel;

  assign pos_sel = (in2_q.parent_kind == gwf_pkg::KIND_LEFT) ? pos_s_q : pos_e_q;
  assign dx_e = (MW+1)'(in2_q.source_x) - $signed({2'b00, pos_e_q});
  assign dx_s = (MW+1)'(in2_q.source_x) - $signed({2'b00, pos_s_q});
  assign dvx  = $signed({3'b000, in2_q.edge_length}) - (MW+1)'(in2_q.opposite_x)
                - $signed({2'b00, pos_sel});
  assign sy_w = (MW+1)'(in2_q.source_y);
  assign oy_w = (MW+1)'(in2_q.opposite_y);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_e_q  <= MW'(dx_e[MW] ? -dx_e : dx_e);
      m_s_q  <= MW'(dx_s[MW] ? -dx_s : dx_s);
      m_v_q  <= MW'(dvx[MW] ? -dvx : dvx);
      m_sy_q <= MW'(sy_w[MW] ? -sy_w : sy_w);
      m_oy_q <= MW'(oy_w[MW] ? -oy_w : oy_w);
      pre3_q.pass       <= (in2_q.parent_kind == gwf_pkg::KIND_PSEUDO);
      pre3_q.from_start <= (in2_q.parent_kind == gwf_pkg::KIND_LEFT);
      pre3_q.known      <= known2_q;
      pre3_q.lhs_l      <= (DW+2)'(in2_q.left_vertex_dist) + (DW+2)'(pos_e_q);
      pre3_q.lhs_r      <= (DW+1)'(in2_q.right_vertex_dist) + (DW+1)'(in2_q.edge_length);
      pre3_q.root       <= in2_q.root_distance;
      pre3_q.root_ps    <= (DW+2)'(in2_q.root_distance) + (DW+2)'(pos_s_q);
      pre3_q.root_m_dop <= $signed({1'b0, in2_q.root_distance})
                           - $signed({1'b0, in2_q.opposite_vertex_dist});
    end
  end

  // Stages 4-5: squares.
  logic [2*MW-1:0] sq_e, sq_s, sq_sy, sq_v, sq_oy;

  gwf_square #(.W(MW)) u_sq_e  (.clk_i, .en_i(en), .a_i(m_e_q),  .sq_o(sq_e));
  gwf_square #(.W(MW)) u_sq_s  (.clk_i, .en_i(en), .a_i(m_s_q),  .sq_o(sq_s));
  gwf_square #(.W(MW)) u_sq_sy (.clk_i, .en_i(en), .a_i(m_sy_q), .sq_o(sq_sy));
  gwf_square #(.W(MW)) u_sq_v  (.clk_i, .en_i(en), .a_i(m_v_q),  .sq_o(sq_v));
  gwf_square #(.W(MW)) u_sq_oy (.clk_i, .en_i(en), .a_i(m_oy_q), .sq_o(sq_oy));

  logic v4_q, v5_q;
  gwf_pkg::gwf_pre_t pre4_q, pre5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre4_q <= pre3_q;
      pre5_q <= pre4_q;
    end
  end

  // Stage 6: sums of squares.
  logic v6_q;
  gwf_pkg::gwf_side_t side6_q;
  logic [1:0][SW-1:0] rad6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side6_q.pre <= pre5_q;
      side6_q.n_o <= SW'(sq_v) + SW'(sq_oy);
      rad6_q[0]   <= SW'(sq_e) + SW'(sq_sy);
      rad6_q[1]   <= SW'(sq_s) + SW'(sq_sy);
    end
  end

  // Square roots: lane 0 is the end length, lane 1 the start length.
  logic vr;
  logic [1:0][RW-1:0] lens;
  gwf_pkg::gwf_side_t sider;

  gwf_isqrt u_isqrt (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (v6_q),
    .rad_i   (rad6_q),
    .side_i  (side6_q),
    .valid_o (vr),
    .root_o  (lens),
    .side_o  (sider)
  );

  // Stage 7: vertex tests and opposite distance margin.
  logic v7_q;
  gwf_pkg::gwf_tail_t tail7_q;
  logic [gwf_pkg::DMAG_W-1:0] dmag7_q;
  logic [RW+1:0] rhs_l, rhs_r;
  logic [RW-1:0] len_sel;
  logic signed [RW+1:0] dval;

  assign rhs_l   = (RW+2)'(sider.pre.root) + (RW+2)'(lens[0]);
  assign rhs_r   = (RW+2)'(sider.pre.root_ps) + (RW+2)'(lens[1]);
  assign len_sel = sider.pre.from_start ? lens[1] : lens[0];
  assign dval    = (RW+2)'(sider.pre.root_m_dop) + $signed({2'b00, len_sel});

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail7_q.pass  <= sider.pre.pass;
      tail7_q.rej_l <= sider.pre.known[0] && ((RW+2)'(sider.pre.lhs_l) < rhs_l);
      tail7_q.rej_r <= sider.pre.known[1] && ((RW+2)'(sider.pre.lhs_r) < rhs_r);
      tail7_q.chk_o <= sider.pre.known[2] && !dval[RW+1] && (dval != '0);
      tail7_q.n_o   <= sider.n_o;
      dmag7_q       <= gwf_pkg::DMAG_W'(dval);
    end
  end

  // Stages 8-9: square of the margin.
  logic [gwf_pkg::DSQ_W-1:0] dsq;
  logic v8_q, v9_q;
  gwf_pkg::gwf_tail_t tail8_q, tail9_q;

  gwf_square #(.W(gwf_pkg::DMAG_W)) u_sq_d (
    .clk_i, .en_i(en), .a_i(dmag7_q), .sq_o(dsq)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail8_q <= tail7_q;
      tail9_q <= tail8_q;
    end
  end

  // Output register: decide in test order.
  logic out_valid_q;
  gwf_pkg::gwf_out_t out_data_q, out_data_d;

  always_comb begin
    out_data_d.reject_reason = gwf_pkg::REASON_NONE;
    if (tail9_q.pass) begin
      out_data_d.reject_reason = gwf_pkg::REASON_NONE;
    end else if (tail9_q.rej_l) begin
      out_data_d.reject_reason = gwf_pkg::REASON_LEFT;
    end else if (tail9_q.rej_r) begin
      out_data_d.reject_reason = gwf_pkg::REASON_RIGHT;
    end else if (tail9_q.chk_o && (gwf_pkg::DSQ_W'(tail9_q.n_o) < dsq)) begin
      out_data_d.reject_reason = gwf_pkg::REASON_OPPOSITE;
    end
    out_data_d.window_valid = (out_data_d.reject_reason == gwf_pkg::REASON_NONE);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  // Valid bits travel with the data; everything advances together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= vr;
      v8_q        <= v7_q;
      v9_q        <= v8_q;
      out_valid_q <= v9_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `GWF_ASSERT_IMPLIES(a_kept_has_no_reason, out_valid_o && out_data_o.window_valid, out_data_o.reject_reason == gwf_pkg::REASON_NONE, "kept window carries a reject reason")
  `GWF_ASSERT_NEXT(a_stall_holds_roots, !en, $stable(vr) && $stable(lens), "root pipeline moved during a stall")
  `GWF_ASSERT_NEXT(a_pseudo_always_kept, en && v9_q && tail9_q.pass, out_valid_o && out_data_o.window_valid, "pseudo-source window was rejected")

endmodule
